@@ hdl/spm_pkg.sv @@
// Shared types, codes and constants for the subword pixel memory port.
// No dependencies; every other file in hdl/ except spm_ram refers to this package by scoped names.
package spm_pkg;

    // Port field widths
    localparam int ADDR_W = 15;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 3;

    // Width of the unreduced word index (byte address divided by 4)
    localparam int WORD_W = ADDR_W - 2;
    localparam int WORD_MAX = (1 << WORD_W) - 1;

    // Width of the lane shift, in bits
    localparam int SHIFT_W = 5;

    // Remainder step counter width; enough for the smallest legal depth
    localparam int STEP_W = 4;

    // Default memory depth in words
    localparam int WORD_DEPTH_DEF = 4096;

    // Action codes
    localparam logic ACT_READ = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Access size codes
    localparam logic [SIZE_W-1:0] SIZE_32 = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_24 = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_16 = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_8 = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_4 = 3'd4;

    // Lane masks
    localparam logic [DATA_W-1:0] MASK_32 = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_24 = 32'h00FF_FFFF;
    localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_8 = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_4 = 32'h0000_000F;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_APPLY
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;      // capture a new transaction
        logic              reduce;    // one conditional-subtract step of the index
        logic [STEP_W-1:0] step;      // shift of the depth for this step
        logic              ram_re;    // read the addressed word
        logic              ram_we;    // write the merged word back
        logic              out_load;  // capture the extracted element
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_write;
        logic size_ok;
    } t_dp_status;

    // Number of conditional-subtract steps that bring the word index below
    // the depth. A power-of-two depth reduces by truncation alone.
    function automatic int rem_steps(input int depth);
        int n;
        n = 0;
        if ((depth & (depth - 1)) != 0) begin
            for (int k = 0; k < 16; k++) begin
                if ((longint'(depth) << k) <= longint'(WORD_MAX)) begin
                    n++;
                end
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/spm_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module spm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/spm_dp.sv @@
// Datapath: transaction registers, index reduction, lane extract and merge, word RAM.
// Depends on spm_pkg and spm_ram.
module spm_dp #(
    parameter int WORD_DEPTH = spm_pkg::WORD_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  spm_pkg::t_ctrl_cmd         i_cmd,
    output spm_pkg::t_dp_status        o_status,
    input  logic                       i_action,
    input  logic [spm_pkg::SIZE_W-1:0] i_access_size,
    input  logic [spm_pkg::ADDR_W-1:0] i_address,
    input  logic [spm_pkg::DATA_W-1:0] i_write_data,
    output logic [spm_pkg::DATA_W-1:0] o_read_data
);

    localparam int IDX_W = $clog2(WORD_DEPTH);
    localparam int WW = spm_pkg::WORD_W;

    logic                        r_action;
    logic                        r_size_ok;
    logic [WW-1:0]               r_word;
    logic [spm_pkg::SHIFT_W-1:0] r_shift;
    logic [spm_pkg::DATA_W-1:0]  r_mask;
    logic [spm_pkg::DATA_W-1:0]  r_data;
    logic [spm_pkg::DATA_W-1:0]  r_read_data;

    logic [WW-1:0]               n_word;
    logic [spm_pkg::SHIFT_W-1:0] n_shift;
    logic [spm_pkg::DATA_W-1:0]  n_mask;
    logic                        n_size_ok;

    logic [31:0]                 w_divisor;
    logic [31:0]                 w_word_ext;
    logic [IDX_W+WW-1:0]         w_index_ext;
    logic [IDX_W-1:0]            w_index;
    logic [spm_pkg::DATA_W-1:0]  w_rdata;
    logic [spm_pkg::DATA_W-1:0]  w_lane;
    logic [spm_pkg::DATA_W-1:0]  w_merged;
    logic [spm_pkg::DATA_W-1:0]  w_element;

    // Decode word index, lane shift and lane mask of the incoming transaction
    always_comb begin
        n_word = i_address[spm_pkg::ADDR_W-1:2];
        n_shift = '0;
        n_mask = '0;
        n_size_ok = 1'b1;
        case (i_access_size)
            spm_pkg::SIZE_32: begin
                n_mask = spm_pkg::MASK_32;
            end
            spm_pkg::SIZE_24: begin
                n_mask = spm_pkg::MASK_24;
            end
            spm_pkg::SIZE_16: begin
                n_shift = {i_address[1], 4'b0000};
                n_mask = spm_pkg::MASK_16;
            end
            spm_pkg::SIZE_8: begin
                n_shift = {i_address[1:0], 3'b000};
                n_mask = spm_pkg::MASK_8;
            end
            spm_pkg::SIZE_4: begin
                n_word = {1'b0, i_address[spm_pkg::ADDR_W-1:3]};
                n_shift = {i_address[2:0], 2'b00};
                n_mask = spm_pkg::MASK_4;
            end
            default: begin
                n_size_ok = 1'b0;
            end
        endcase
    end

    // One restoring-remainder step: subtract the shifted depth if it fits
    assign w_divisor = 32'(WORD_DEPTH) << i_cmd.step;
    assign w_word_ext = {{(32 - WW){1'b0}}, r_word};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_size_ok <= n_size_ok;
            r_word <= n_word;
            r_shift <= n_shift;
            r_mask <= n_mask;
            r_data <= i_write_data & n_mask;
        end else if (i_cmd.reduce && (w_word_ext >= w_divisor)) begin
            r_word <= WW'(w_word_ext - w_divisor);
        end
    end

    // Reduced word fits the depth; widen or truncate to the RAM index
    assign w_index_ext = {{IDX_W{1'b0}}, r_word};
    assign w_index = w_index_ext[IDX_W-1:0];

    // Replace only the addressed lane of the stored word
    assign w_lane = r_mask << r_shift;
    assign w_merged = (w_rdata & ~w_lane) | (r_data << r_shift);
    assign w_element = (w_rdata >> r_shift) & r_mask;

    spm_ram #(
        .WIDTH(spm_pkg::DATA_W),
        .DEPTH(WORD_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_re   (i_cmd.ram_re),
        .i_addr (w_index),
        .i_wdata(w_merged),
        .o_rdata(w_rdata)
    );

    // Hold the element for the result strobe; unused sizes read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_read_data <= r_size_ok ? w_element : '0;
        end
    end

    assign o_status.is_write = (r_action == spm_pkg::ACT_WRITE);
    assign o_status.size_ok = r_size_ok;
    assign o_read_data = r_read_data;

endmodule

@@ hdl/spm_ctrl.sv @@
// Controller: sequences index reduction, word read and lane apply per transaction.
// Depends on spm_pkg.
module spm_ctrl #(
    parameter int WORD_DEPTH = spm_pkg::WORD_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_strobe,
    output spm_pkg::t_ctrl_cmd  o_cmd,
    input  spm_pkg::t_dp_status i_status
);

    localparam int REM_STEPS = spm_pkg::rem_steps(WORD_DEPTH);
    localparam logic [spm_pkg::STEP_W-1:0] FIRST_STEP =
        (REM_STEPS > 0) ? spm_pkg::STEP_W'(REM_STEPS - 1) : '0;

    spm_pkg::t_state             r_state;
    spm_pkg::t_state             n_state;
    logic [spm_pkg::STEP_W-1:0]  r_step;
    logic [spm_pkg::STEP_W-1:0]  n_step;
    logic                        r_strobe;
    logic                        n_strobe;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spm_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (REM_STEPS > 0) ? spm_pkg::ST_REDUCE : spm_pkg::ST_READ;
                end
            end
            spm_pkg::ST_REDUCE: begin
                if (r_step == '0) begin
                    n_state = spm_pkg::ST_READ;
                end
            end
            spm_pkg::ST_READ: begin
                n_state = spm_pkg::ST_APPLY;
            end
            spm_pkg::ST_APPLY: begin
                n_state = spm_pkg::ST_IDLE;
            end
            default: begin
                n_state = spm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and step counter
    always_comb begin
        o_cmd = '0;
        n_step = r_step;
        n_strobe = 1'b0;
        case (r_state)
            spm_pkg::ST_IDLE: begin
                o_cmd.load = start;
                n_step = FIRST_STEP;
            end
            spm_pkg::ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                o_cmd.step = r_step;
                n_step = r_step - 1'b1;
            end
            spm_pkg::ST_READ: begin
                o_cmd.ram_re = 1'b1;
            end
            spm_pkg::ST_APPLY: begin
                o_cmd.ram_we = i_status.is_write && i_status.size_ok;
                o_cmd.out_load = !i_status.is_write;
                n_strobe = !i_status.is_write;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::ST_IDLE;
            r_step <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_strobe <= n_strobe;
        end
    end

    assign busy = (r_state != spm_pkg::ST_IDLE);
    assign o_strobe = r_strobe;

endmodule

@@ hdl/subword_pixel_memory_port.sv @@
// Top level of the subword pixel memory port: controller plus datapath.
// Depends on spm_pkg, spm_ctrl, spm_dp (and spm_ram through the datapath).
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. It carries i_action (read or write), i_access_size
//   (32/24/16/8/4-bit element), i_address (byte address, nibble address for
//   4-bit access) and i_write_data (low bits used on writes).
//   Result channel: a read returns the zero-extended element on o_read_data
//   with o_strobe high for one cycle; a write returns nothing. The receiver
//   cannot stall, so results are never held.
//   Timing: busy rises the cycle after acceptance; o_strobe rises once the
//   remainder steps, the word read and the lane apply are done, and a new
//   transaction can be taken at the edge that ends the strobe cycle. The
//   single RAM port orders the work (accept, read, then lane merge and write
//   back); the remainder steps that fold the word index into the depth come
//   between accept and read: zero steps for a power-of-two depth.
//   Reset: synchronous, active low; clears the controller only. The pixel
//   words are undefined until written and get no clearing pass.
module subword_pixel_memory_port #(
    parameter int WORD_DEPTH = spm_pkg::WORD_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_action,
    input  logic [spm_pkg::SIZE_W-1:0] i_access_size,
    input  logic [spm_pkg::ADDR_W-1:0] i_address,
    input  logic [spm_pkg::DATA_W-1:0] i_write_data,
    output logic                       o_strobe,
    output logic [spm_pkg::DATA_W-1:0] o_read_data
);

    spm_pkg::t_ctrl_cmd  w_cmd;
    spm_pkg::t_dp_status w_status;

    spm_ctrl #(
        .WORD_DEPTH(WORD_DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_cmd   (w_cmd),
        .i_status(w_status)
    );

    spm_dp #(
        .WORD_DEPTH(WORD_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_action),
        .i_access_size(i_access_size),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_read_data  (o_read_data)
    );

endmodule

@@ hdl/spm_checker.sv @@
// Port-level checker for the subword pixel memory port, bound to the top level.
// Depends on spm_pkg and subword_pixel_memory_port.
module spm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_action,
    input logic o_strobe
);

    // Accepted transaction keeps the port busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // Results appear only once the port is free again
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // A result follows a busy period and never repeats in the next cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) ##1 !o_strobe))
        else $error("result strobe not preceded by work or held two cycles");

    // Right after an accepted write, no result strobe appears
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == spm_pkg::ACT_WRITE))
            |=> !o_strobe ##1 !o_strobe)
        else $error("result strobe after a write");

endmodule

bind subword_pixel_memory_port spm_checker u_spm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_action(i_action),
    .o_strobe(o_strobe)
);

@@ tb/tb_subword_pixel_memory_port.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for subword_pixel_memory_port: directed and random element accesses.
// Depends on spm_pkg and the RTL in hdl/; holds its own word-level memory predictor.
module tb_subword_pixel_memory_port;

    import spm_pkg::*;

    localparam int PIXEL_DEPTH = WORD_DEPTH_DEF;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 530;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_action = ACT_READ;
    logic [SIZE_W-1:0] i_access_size = SIZE_32;
    logic [ADDR_W-1:0] i_address = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_strobe;
    logic [DATA_W-1:0] o_read_data;

    // Predicted memory image and the bits that have been written so far
    bit [DATA_W-1:0] pixel_model [PIXEL_DEPTH];
    bit [DATA_W-1:0] written_bits [PIXEL_DEPTH];
    logic [DATA_W-1:0] read_expect_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    subword_pixel_memory_port #(
        .WORD_DEPTH(PIXEL_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_access_size(i_access_size),
        .i_address(i_address),
        .i_write_data(i_write_data),
        .o_strobe(o_strobe),
        .o_read_data(o_read_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[subword_pixel_memory_port] ERROR");
            $finish;
        end
    end

    // Word index, lane shift and lane mask of one access; 0 for an unused size code
    function automatic bit locate_lane(input logic [SIZE_W-1:0] size,
                                       input logic [ADDR_W-1:0] addr,
                                       output int unsigned word_idx,
                                       output int unsigned lane_shift,
                                       output logic [DATA_W-1:0] lane_mask);
        int unsigned word_num;
        word_num = int'(addr) >> 2;
        word_idx = 0;
        lane_shift = 0;
        lane_mask = '0;
        case (size)
            SIZE_32: lane_mask = MASK_32;
            SIZE_24: lane_mask = MASK_24;
            SIZE_16: begin
                lane_shift = int'(addr[1]) * 16;
                lane_mask = MASK_16;
            end
            SIZE_8: begin
                lane_shift = int'(addr[1:0]) * 8;
                lane_mask = MASK_8;
            end
            SIZE_4: begin
                word_num = int'(addr) >> 3;
                lane_shift = int'(addr[2:0]) * 4;
                lane_mask = MASK_4;
            end
            default: return 1'b0;
        endcase
        word_idx = word_num % PIXEL_DEPTH;
        return 1'b1;
    endfunction

    // Apply one accepted transaction to the memory image; queue the element a read returns
    function automatic void model_pixel_access(input logic act, input logic [SIZE_W-1:0] size,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] data);
        int unsigned idx;
        int unsigned sh;
        logic [DATA_W-1:0] msk;
        bit ok;
        ok = locate_lane(size, addr, idx, sh, msk);
        if (act == ACT_READ) begin
            read_expect_q.push_back(ok ? (pixel_model[idx] >> sh) & msk : '0);
        end else if (ok) begin
            pixel_model[idx] = (pixel_model[idx] & ~(msk << sh)) | ((data & msk) << sh);
            written_bits[idx] = written_bits[idx] | (msk << sh);
        end
    endfunction

    // True when a read of this element touches only bits that were written
    function automatic bit lane_written(input logic [SIZE_W-1:0] size,
                                        input logic [ADDR_W-1:0] addr);
        int unsigned idx;
        int unsigned sh;
        logic [DATA_W-1:0] msk;
        if (!locate_lane(size, addr, idx, sh, msk)) return 1'b1;
        return ((msk << sh) & ~written_bits[idx]) == '0;
    endfunction

    // Offer one transaction after an optional idle gap, hold it until taken, then advance the predictor
    task automatic send_item(input logic act, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                             input bit may_idle);
        int unsigned gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_access_size <= size;
        i_address <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (busy !== 1'b0);
        model_pixel_access(act, size, addr, data);
    endtask

    // Compare each strobed element with the oldest pending read
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (read_expect_q.size() == 0) begin
                $error("read_data: unexpected result 0x%08h", o_read_data);
                mismatch_count++;
            end else begin
                if (o_read_data !== read_expect_q[0]) begin
                    $error("read_data: expected 0x%08h, actual 0x%08h",
                           read_expect_q[0], o_read_data);
                    mismatch_count++;
                end
                void'(read_expect_q.pop_front());
            end
        end
    end

    task automatic test_full_word();
        send_item(ACT_WRITE, SIZE_32, 15'h0000, 32'hFFFF_FFFF, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h0003, 32'h0, 1'b1);
        send_item(ACT_WRITE, SIZE_32, 15'h0004, 32'h0, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h0004, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Cut-down write values must leave neighboring lanes alone
    task automatic test_partial_lanes();
        send_item(ACT_WRITE, SIZE_24, 15'h0002, 32'hAABB_CCDD, 1'b1);
        send_item(ACT_READ, SIZE_24, 15'h0001, 32'h0, 1'b1);
        send_item(ACT_WRITE, SIZE_16, 15'h0003, 32'h1234_5678, 1'b1);
        send_item(ACT_READ, SIZE_16, 15'h0002, 32'h0, 1'b1);
        send_item(ACT_WRITE, SIZE_8, 15'h0001, 32'h0000_01FF, 1'b1);
        send_item(ACT_READ, SIZE_8, 15'h0001, 32'h0, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h0000, 32'h0, 1'b1);
    endtask

    task automatic test_nibble_lanes();
        send_item(ACT_WRITE, SIZE_4, 15'h000F, 32'hFFFF_FFF7, 1'b1);
        send_item(ACT_READ, SIZE_4, 15'h000F, 32'h0, 1'b1);
        send_item(ACT_READ, SIZE_4, 15'h0008, 32'h0, 1'b1);
    endtask

    // Top word, highest addresses and word indexes past the depth
    task automatic test_wrap_and_extremes();
        send_item(ACT_WRITE, SIZE_32, 15'h3FFC, 32'hA5A5_A5A5, 1'b1);
        send_item(ACT_WRITE, SIZE_8, 15'h7FFF, 32'h0000_003C, 1'b1);
        send_item(ACT_WRITE, SIZE_4, 15'h7FFF, 32'h0000_000E, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h7FFC, 32'h0, 1'b1);
        send_item(ACT_WRITE, SIZE_16, 15'h4000, 32'h0000_BEEF, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h0000, 32'h0, 1'b1);
    endtask

    // Unused size codes: a read returns zero, a write is dropped
    task automatic test_unused_sizes();
        send_item(ACT_WRITE, 3'd5, 15'h0000, 32'hFFFF_FFFF, 1'b1);
        send_item(ACT_READ, 3'd7, 15'h7FFF, 32'h0, 1'b1);
        send_item(ACT_READ, 3'd6, 15'h0000, 32'h0, 1'b1);
        send_item(ACT_READ, SIZE_32, 15'h0000, 32'h0, 1'b1);
    endtask

    // Mostly a small pool of words so reads hit written lanes; some fully random addresses
    task automatic test_random_traffic();
        int unsigned pool [11] = '{0, 1, 2, 3, 4, 5, 6, 7, 2047, 4094, 4095};
        int unsigned word_sel;
        logic act;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int unsigned pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            pick = $urandom_range(0, 19);
            size = (pick < 18) ? SIZE_W'(pick % 5) : SIZE_W'($urandom_range(5, 7));
            word_sel = pool[$urandom_range(0, 10)];
            if ($urandom_range(0, 4) == 0) begin
                addr = ADDR_W'($urandom);
            end else if (size == SIZE_4) begin
                addr = ADDR_W'((word_sel << 3) | $urandom_range(0, 7));
            end else begin
                addr = ADDR_W'(($urandom_range(0, 1) << 14) | (word_sel << 2)
                               | $urandom_range(0, 3));
            end
            pick = $urandom_range(0, 9);
            data = (pick == 0) ? '0 : (pick == 1) ? MASK_32 : DATA_W'($urandom);
            // Turn a read of unwritten bits into a write of that element
            if (act == ACT_READ && !lane_written(size, addr)) act = ACT_WRITE;
            // Run a long stretch back to back
            send_item(act, size, addr, data, !(n >= 200 && n < 330));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_full_word();
        test_partial_lanes();
        test_nibble_lanes();
        test_wrap_and_extremes();
        test_unused_sizes();
        test_random_traffic();
        start <= 1'b0;
        // Drain outstanding reads, then let the pipeline settle
        while (read_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[subword_pixel_memory_port] OK");
        end else begin
            $display("[subword_pixel_memory_port] ERROR");
        end
        $finish;
    end

endmodule
